@@ sv/bns_pkg.sv @@
`timescale 1ns / 1ps
// Package of the block noise statistics datapath: field widths and the
// stage records that pass between the scan, square and accumulate modules.
package bns_pkg;

  localparam int SAMPLE_W  = 12;  // width of a sample field on the port
  localparam int BSIZE_W   = 4;   // width of the block size register
  localparam int SSD_W     = 30;  // width of sum_sq_diff
  localparam int GRAD_W    = 33;  // width of gradient_sum
  localparam int DIFF_W    = SAMPLE_W + 1;  // signed source minus reference
  localparam int DELTA_W   = SAMPLE_W + 2;  // signed change of difference
  localparam int VSQ_W     = 2 * SAMPLE_W;  // square of |difference|
  localparam int DSQ_W     = 2 * (SAMPLE_W + 1);  // square of |change|
  localparam int GSTEP_W   = DSQ_W + 1;  // left term plus upper term

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = 4'd8;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] left;
    logic signed [DIFF_W-1:0] upper;
    logic                     has_left;
    logic                     has_upper;
    logic                     last;
  } bns_scan_t;

  typedef struct packed {
    logic [VSQ_W-1:0]   var_sq;
    logic [GSTEP_W-1:0] grad_sq;
    logic               last;
  } bns_energy_t;

endpackage

@@ sv/bns_if.sv @@
`timescale 1ns / 1ps
// Handshake channels of the block noise statistics block: sample pairs in,
// block size writes, and results out. Depends on bns_pkg for widths.
interface bns_in_if;
  logic                          valid;
  logic                          ready;
  logic [bns_pkg::SAMPLE_W-1:0]  src_sample;
  logic [bns_pkg::SAMPLE_W-1:0]  ref_sample;
  modport source (output valid, output src_sample, output ref_sample, input ready);
  modport sink   (input valid, input src_sample, input ref_sample, output ready);
endinterface

interface bns_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bns_pkg::BSIZE_W-1:0]   block_size;
  modport source (output valid, output block_size, input ready);
  modport sink   (input valid, input block_size, output ready);
endinterface

interface bns_out_if;
  logic                          valid;
  logic                          ready;
  logic [bns_pkg::SSD_W-1:0]     sum_sq_diff;
  logic [bns_pkg::GRAD_W-1:0]    gradient_sum;
  modport source (output valid, output sum_sq_diff, output gradient_sum, input ready);
  modport sink   (input valid, input sum_sq_diff, input gradient_sum, output ready);
endinterface

@@ sv/bns_scan.sv @@
`timescale 1ns / 1ps
// Scan stage: block size register, column/row counters, difference forming,
// left neighbor register and the one-row line memory. Depends on bns_pkg.
module bns_scan #(
  parameter int MAX_BLOCK_SIZE = 8,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bns_pkg::BSIZE_W-1:0]     cfg_size_i,
  input  logic                            advance_i,
  input  logic                            in_valid_i,
  input  logic [bns_pkg::SAMPLE_W-1:0]    src_sample_i,
  input  logic [bns_pkg::SAMPLE_W-1:0]    ref_sample_i,
  output logic                            in_ready_o,
  output logic                            valid_o,
  output bns_pkg::bns_scan_t              scan_o
);
  import bns_pkg::*;

  localparam int CW    = $clog2(MAX_BLOCK_SIZE);
  localparam int CMPW  = (CW > BSIZE_W) ? CW : BSIZE_W;
  localparam int CAP   = (MAX_BLOCK_SIZE < 15) ? MAX_BLOCK_SIZE : 15;
  localparam int USED  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SMASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - USED);

  logic [BSIZE_W-1:0]       bsize_q;
  logic [BSIZE_W-1:0]       eff_size;
  logic [CW-1:0]            col_q, row_q;
  logic                     col_last, row_last;
  logic                     accept;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] left_q;
  logic signed [DIFF_W-1:0] line_mem [MAX_BLOCK_SIZE];
  logic signed [DIFF_W-1:0] upper_q;
  logic signed [DIFF_W-1:0] diff1_q, left1_q;
  logic                     has_left1_q, has_upper1_q, last1_q;
  logic                     valid_q;

  always_comb begin
    if (bsize_q == '0) begin
      eff_size = BSIZE_W'(1);
    end else if (bsize_q > BSIZE_W'(CAP)) begin
      eff_size = BSIZE_W'(CAP);
    end else begin
      eff_size = bsize_q;
    end
  end

  assign col_last   = (CMPW'(col_q) == CMPW'(eff_size - BSIZE_W'(1)));
  assign row_last   = (CMPW'(row_q) == CMPW'(eff_size - BSIZE_W'(1)));
  assign in_ready_o = advance_i;
  assign accept     = in_valid_i & advance_i;
  assign diff       = $signed({1'b0, src_sample_i & SMASK})
                    - $signed({1'b0, ref_sample_i & SMASK});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q <= BSIZE_RESET;
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        // a new size abandons any partial block
        bsize_q <= cfg_size_i;
        col_q   <= '0;
        row_q   <= '0;
      end else if (accept) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_last ? '0 : row_q + CW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (advance_i) begin
        valid_q <= accept;
      end
    end
  end

  // Line memory: read-first, so the same-column read returns the upper row.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      upper_q         <= line_mem[col_q];
      line_mem[col_q] <= diff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q       <= diff;
      diff1_q      <= diff;
      left1_q      <= left_q;
      has_left1_q  <= (col_q != '0);
      has_upper1_q <= (row_q != '0);
      last1_q      <= col_last & row_last;
    end
  end

  assign valid_o          = valid_q;
  assign scan_o.diff      = diff1_q;
  assign scan_o.left      = left1_q;
  assign scan_o.upper     = upper_q;
  assign scan_o.has_left  = has_left1_q;
  assign scan_o.has_upper = has_upper1_q;
  assign scan_o.last      = last1_q;

endmodule

@@ sv/bns_energy.sv @@
`timescale 1ns / 1ps
// Square stage: squares the difference and its changes toward the left and
// upper neighbors, registered. Depends on bns_pkg.
module bns_energy (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 valid_i,
  input  bns_pkg::bns_scan_t   scan_i,
  output logic                 valid_o,
  output bns_pkg::bns_energy_t energy_o
);
  import bns_pkg::*;

  logic signed [DELTA_W-1:0] dl, du;
  logic [SAMPLE_W-1:0]       mag_d;
  logic [SAMPLE_W:0]         mag_l, mag_u;
  logic [VSQ_W-1:0]          sq_d;
  logic [DSQ_W-1:0]          sq_l, sq_u;
  logic                      valid_q;
  bns_energy_t               energy_q;

  always_comb begin
    dl    = DELTA_W'(scan_i.diff) - DELTA_W'(scan_i.left);
    du    = DELTA_W'(scan_i.diff) - DELTA_W'(scan_i.upper);
    mag_d = scan_i.diff[DIFF_W-1] ? SAMPLE_W'(-scan_i.diff) : SAMPLE_W'(scan_i.diff);
    mag_l = dl[DELTA_W-1] ? (SAMPLE_W + 1)'(-dl) : (SAMPLE_W + 1)'(dl);
    mag_u = du[DELTA_W-1] ? (SAMPLE_W + 1)'(-du) : (SAMPLE_W + 1)'(du);
    sq_d  = mag_d * mag_d;
    sq_l  = scan_i.has_left  ? mag_l * mag_l : '0;
    sq_u  = scan_i.has_upper ? mag_u * mag_u : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && valid_i) begin
      energy_q.var_sq  <= sq_d;
      energy_q.grad_sq <= GSTEP_W'(sq_l) + GSTEP_W'(sq_u);
      energy_q.last    <= scan_i.last;
    end
  end

  assign valid_o  = valid_q;
  assign energy_o = energy_q;

endmodule

@@ sv/bns_accum.sv @@
`timescale 1ns / 1ps
// Accumulate stage: variance and gradient sums, result register and the
// stall that holds the pipeline when a block end meets a waiting result. Uses bns_pkg.
module bns_accum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         valid_i,
  input  bns_pkg::bns_energy_t         energy_i,
  output logic                         advance_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [bns_pkg::SSD_W-1:0]    sum_sq_diff_o,
  output logic [bns_pkg::GRAD_W-1:0]   gradient_sum_o
);
  import bns_pkg::*;

  logic [SSD_W-1:0]  var_acc_q, var_next;
  logic [GRAD_W-1:0] grad_acc_q, grad_next;
  logic              res_valid_q;
  logic [SSD_W-1:0]  ssd_q;
  logic [GRAD_W-1:0] grad_q;
  logic              fire, emit;

  // hold only when a block end would land on an untaken result
  assign advance_o = !(valid_i && energy_i.last && res_valid_q && !res_ready_i);
  assign fire      = valid_i & advance_o;
  assign emit      = fire & energy_i.last;
  assign var_next  = var_acc_q + SSD_W'(energy_i.var_sq);
  assign grad_next = grad_acc_q + GRAD_W'(energy_i.grad_sq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_acc_q   <= '0;
      grad_acc_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i || emit) begin
        var_acc_q  <= '0;
        grad_acc_q <= '0;
      end else if (fire) begin
        var_acc_q  <= var_next;
        grad_acc_q <= grad_next;
      end
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ssd_q  <= var_next;
      grad_q <= grad_next;
    end
  end

  assign res_valid_o    = res_valid_q;
  assign sum_sq_diff_o  = ssd_q;
  assign gradient_sum_o = grad_q;

endmodule

@@ sv/block_noise_statistics.sv @@
`timescale 1ns / 1ps
// Block noise statistics: sum of squared source/reference differences and
// gradient energy of the difference over one square block.
//
// Channels: src_i takes one source/reference sample pair per item in raster
// order within the block. cfg_i writes the block edge length (0 acts as 1,
// values above MAX_BLOCK_SIZE saturate); a write clears the position and the
// sums. The user must see that it is issued only while no item is in flight;
// the block does not enforce this. res_o carries one result item per
// completed block: sum_sq_diff and gradient_sum. Throughput: one sample pair
// per cycle, sustained across block borders unless the stall below holds.
// Result path: scan registers, square stage register, accumulate register.
// Reset: block size 8, position and sums cleared, no result pending.
// Stall: a waiting result does not stop intake; the pipeline holds only when
// the next block end reaches the accumulator before the result is taken.
// Depends on bns_pkg, bns_if, bns_scan, bns_energy and bns_accum.
module block_noise_statistics #(
  parameter int MAX_BLOCK_SIZE = 8,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  bns_in_if.sink    src_i,
  bns_cfg_if.sink   cfg_i,
  bns_out_if.source res_o
);
  import bns_pkg::*;

  logic        cfg_we;
  logic        advance;
  logic        scan_valid, energy_valid;
  bns_scan_t   scan;
  bns_energy_t energy;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  bns_scan #(
    .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_size_i   (cfg_i.block_size),
    .advance_i    (advance),
    .in_valid_i   (src_i.valid),
    .src_sample_i (src_i.src_sample),
    .ref_sample_i (src_i.ref_sample),
    .in_ready_o   (src_i.ready),
    .valid_o      (scan_valid),
    .scan_o       (scan)
  );

  bns_energy u_energy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (scan_valid),
    .scan_i    (scan),
    .valid_o   (energy_valid),
    .energy_o  (energy)
  );

  bns_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .valid_i        (energy_valid),
    .energy_i       (energy),
    .advance_o      (advance),
    .res_valid_o    (res_o.valid),
    .res_ready_i    (res_o.ready),
    .sum_sq_diff_o  (res_o.sum_sq_diff),
    .gradient_sum_o (res_o.gradient_sum)
  );

endmodule
